// ----- hdl/ispl_pkg.sv -----
// ----------------------------------------------------------------------------
// ispl_pkg: shared types and constants of the interval slot planner
// Word layouts for the item and result channels, function and status codes,
// and the configuration register map.
// ----------------------------------------------------------------------------
package ispl_pkg;

  localparam int unsigned StepW   = 16;
  localparam int unsigned SizeW   = 32;
  localparam int unsigned IdW     = 16;
  localparam int unsigned OffW    = 40;
  localparam int unsigned SlotIdW = 5;

  // configuration
  localparam int unsigned       PaddrW     = 3;
  localparam int unsigned       PdataW     = 32;
  localparam int unsigned       AlignW     = 4;
  localparam logic [AlignW-1:0] AlignReset = 4'd6;
  localparam logic [AlignW-1:0] AlignMax   = 4'd12;

  typedef enum logic {
    RegAlign = 1'b0
  } reg_idx_e;

  typedef enum logic {
    FuncPlace  = 1'b0,
    FuncFinish = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusFull     = 2'd1,
    StatusOverflow = 2'd2
  } status_e;

  typedef struct packed {
    logic [0:0]       func;
    logic [StepW-1:0] start_step;
    logic [StepW-1:0] end_step;
    logic [SizeW-1:0] byte_count;
    logic [IdW-1:0]   value_id;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [IdW-1:0]     echo_value_id;
    logic [SlotIdW-1:0] slot_index;
    logic [0:0]         opened_slot;
    logic [0:0]         slot_valid;
    logic [OffW-1:0]    slot_offset;
    logic [SizeW-1:0]   slot_capacity;
    logic [OffW-1:0]    total_bytes;
    logic [0:0]         last;
  } out_word_t;

endpackage

// ----- hdl/ispl_stream_if.sv -----
// ----------------------------------------------------------------------------
// ispl_stream_if: valid/ready channel
// Carries one word per handshake; source drives valid and data, sink ready.
// ----------------------------------------------------------------------------
interface ispl_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/interval_slot_planner_core.sv -----
// ----------------------------------------------------------------------------
// interval_slot_planner_core: greedy buffer slot planner
// Assigns buffer lifetimes to reusable slots and emits the slot layout.
// ----------------------------------------------------------------------------
// One item is handled at a time; in_i.ready is high only while the block is
// idle. A place word scans the n slots in use through the single read port of
// the slot RAM, one slot per cycle, then loads its result word once the
// output register is free, and the block returns to idle as that word is
// loaded. A finish word handles each slot as a RAM read, then an offset
// add, and gives one result word per slot, or a single word when the table
// is empty. The result sits in an output register, so a waiting result does
// not hold back the sequencer until the next one is due.
// Slot offsets are aligned to 2^alignment_log2 bytes (values above 12 act as
// 12). With at most 32 slots of 32-bit capacity the total stays far below
// 2^40, so finish results always carry status ok.
module interval_slot_planner_core #(
  parameter int unsigned MAX_SLOTS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ispl_pkg::PaddrW-1:0]  paddr,
  input  logic [ispl_pkg::PdataW-1:0]  pwdata,
  output logic [ispl_pkg::PdataW-1:0]  prdata,
  output logic                         pready,
  ispl_stream_if.sink                  in_i,
  ispl_stream_if.source                out_o
);

  localparam int unsigned IdxW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_SLOTS + 1);
  localparam int unsigned StepW = ispl_pkg::StepW;
  localparam int unsigned SizeW = ispl_pkg::SizeW;
  localparam int unsigned OffW  = ispl_pkg::OffW;
  localparam int unsigned RamW  = StepW + SizeW;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StScan  = 6'b000010,
    StPlace = 6'b000100,
    StFrd   = 6'b001000,
    StFemit = 6'b010000,
    StEmpty = 6'b100000
  } state_e;

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  logic [ispl_pkg::AlignW-1:0] align_q;
  logic                        reg_hit;
  logic [ispl_pkg::AlignW-1:0] align_lg;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == ispl_pkg::RegAlign);
  assign prdata  = reg_hit ? ispl_pkg::PdataW'(align_q) : '0;
  assign align_lg = (align_q > ispl_pkg::AlignMax) ? ispl_pkg::AlignMax : align_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      align_q <= ispl_pkg::AlignReset;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      align_q <= pwdata[ispl_pkg::AlignW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // slot RAM: {busy_until, capacity}
  // --------------------------------------------------------------------------
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  logic [RamW-1:0] ram_wdata;
  logic [RamW-1:0] ram_rdata;
  logic [StepW-1:0] rd_busy;
  logic [SizeW-1:0] rd_cap;

  // control
  state_e          state_q, state_d;
  logic [CntW-1:0] n_q, n_d;
  logic [CntW-1:0] ptr_q, ptr_d;
  logic            pv_q, pv_d;
  logic            found_q, found_d;
  logic            out_valid_q, out_valid_d;

  // payload
  ispl_pkg::in_word_t  item_q;
  ispl_pkg::out_word_t out_q, out_d;
  logic                out_load;
  logic [IdxW-1:0]     pidx_q, pidx_d;
  logic [IdxW-1:0]     sel_q, sel_d;
  logic [SizeW-1:0]    best_q, best_d;
  logic [SizeW-1:0]    bcap_q, bcap_d;
  logic [OffW-1:0]     total_q, total_d;
  logic [OffW-1:0]     off_q, off_d;

  logic             accept;
  logic             out_free;
  logic [SizeW-1:0] growth;
  logic [SizeW-1:0] new_cap;
  logic [OffW-1:0]  align_mask;
  logic [OffW-1:0]  slot_end;

  ispl_ram #(
    .Width (RamW),
    .Depth (MAX_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ptr_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rd_busy = ram_rdata[RamW-1:SizeW];
  assign rd_cap  = ram_rdata[SizeW-1:0];

  assign in_i.ready  = (state_q == StIdle);
  assign accept      = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  assign growth     = (item_q.byte_count > rd_cap) ? item_q.byte_count - rd_cap : '0;
  assign new_cap    = (item_q.byte_count > bcap_q) ? item_q.byte_count : bcap_q;
  assign align_mask = (OffW'(1) << align_lg) - OffW'(1);
  assign slot_end   = off_q + OffW'(rd_cap);

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    ptr_d       = ptr_q;
    pv_d        = pv_q;
    found_d     = found_q;
    pidx_d      = pidx_q;
    sel_d       = sel_q;
    best_d      = best_q;
    bcap_d      = bcap_q;
    total_d     = total_q;
    off_d       = off_q;
    out_d       = out_q;
    out_load    = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = sel_q;
    ram_wdata   = {item_q.end_step, new_cap};

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          ptr_d   = '0;
          pv_d    = 1'b0;
          found_d = 1'b0;
          total_d = '0;
          if (in_i.data.func == ispl_pkg::FuncPlace) begin
            state_d = StScan;
          end else if (n_q == '0) begin
            state_d = StEmpty;
          end else begin
            state_d = StFrd;
          end
        end
      end

      // one RAM read issued per cycle, the previous one evaluated
      StScan: begin
        if (pv_q && (rd_busy < item_q.start_step) && (!found_q || growth < best_q)) begin
          found_d = 1'b1;
          sel_d   = pidx_q;
          best_d  = growth;
          bcap_d  = rd_cap;
        end
        if (ptr_q < n_q) begin
          pv_d   = 1'b1;
          pidx_d = ptr_q[IdxW-1:0];
          ptr_d  = ptr_q + CntW'(1);
        end else begin
          pv_d = 1'b0;
          if (!pv_q) begin
            state_d = StPlace;
          end
        end
      end

      StPlace: begin
        if (out_free) begin
          out_load            = 1'b1;
          state_d             = StIdle;
          out_d               = '0;
          out_d.echo_value_id = item_q.value_id;
          out_d.last          = 1'b1;
          if (found_q) begin
            ram_we              = 1'b1;
            out_d.status        = ispl_pkg::StatusOk;
            out_d.slot_index    = ispl_pkg::SlotIdW'(sel_q);
            out_d.slot_valid    = 1'b1;
            out_d.slot_capacity = new_cap;
          end else if (n_q == CntW'(MAX_SLOTS)) begin
            out_d.status = ispl_pkg::StatusFull;
          end else begin
            ram_we              = 1'b1;
            ram_waddr           = n_q[IdxW-1:0];
            ram_wdata           = {item_q.end_step, item_q.byte_count};
            n_d                 = n_q + CntW'(1);
            out_d.status        = ispl_pkg::StatusOk;
            out_d.slot_index    = ispl_pkg::SlotIdW'(n_q);
            out_d.opened_slot   = 1'b1;
            out_d.slot_valid    = 1'b1;
            out_d.slot_capacity = item_q.byte_count;
          end
        end
      end

      // read slot ptr, round running total up to the alignment
      StFrd: begin
        off_d   = (total_q + align_mask) & ~align_mask;
        state_d = StFemit;
      end

      StFemit: begin
        if (out_free) begin
          out_load            = 1'b1;
          out_d               = '0;
          out_d.status        = ispl_pkg::StatusOk;
          out_d.slot_index    = ispl_pkg::SlotIdW'(ptr_q);
          out_d.slot_valid    = 1'b1;
          out_d.slot_offset   = off_q;
          out_d.slot_capacity = rd_cap;
          total_d             = slot_end;
          ptr_d               = ptr_q + CntW'(1);
          if (ptr_d == n_q) begin
            out_d.total_bytes = slot_end;
            out_d.last        = 1'b1;
            n_d               = '0;
            state_d           = StIdle;
          end else begin
            state_d = StFrd;
          end
        end
      end

      StEmpty: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_d        = '0;
          out_d.status = ispl_pkg::StatusOk;
          out_d.last   = 1'b1;
          state_d      = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      n_q         <= '0;
      ptr_q       <= '0;
      pv_q        <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      ptr_q       <= ptr_d;
      pv_q        <= pv_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_i.data;
    end
    pidx_q  <= pidx_d;
    sel_q   <= sel_d;
    best_q  <= best_d;
    bcap_q  <= bcap_d;
    total_q <= total_d;
    off_q   <= off_d;
    out_q   <= out_d;
  end

endmodule

// ----- hdl/ispl_ram.sv -----
// ----------------------------------------------------------------------------
// ispl_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data. No reset.
// ----------------------------------------------------------------------------
module ispl_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 32
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- test/ispl_layout_checker.sv -----
// ----------------------------------------------------------------------------
// ispl_layout_checker: result checker for the interval slot planner
// Watches the item, result and configuration buses, keeps its own copy of the
// slot table, predicts every result word and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ispl_layout_checker #(
  parameter int unsigned SLOTS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  ispl_pkg::in_word_t          in_data_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  ispl_pkg::out_word_t         out_data_i,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic                        pready_i,
  input  logic [ispl_pkg::PaddrW-1:0] paddr_i,
  input  logic [ispl_pkg::PdataW-1:0] pwdata_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o
);

  localparam logic [ispl_pkg::PaddrW-1:0] AlignAddr =
      ispl_pkg::PaddrW'(4 * int'(ispl_pkg::RegAlign));

  logic [ispl_pkg::SizeW-1:0]  slot_cap  [SLOTS];
  logic [ispl_pkg::StepW-1:0]  slot_busy [SLOTS];
  int unsigned                 slots_used;
  logic [ispl_pkg::AlignW-1:0] align_log2;
  ispl_pkg::out_word_t         layout_q[$];
  ispl_pkg::out_word_t         want;
  int unsigned                 fail_total;

  function automatic void note_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (exp_v !== got_v) begin
      fail_total++;
      if (fail_total <= 10)
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, got_v);
    end
  endfunction

  // greedy pick: free slot with least capacity growth, lowest index on ties
  function automatic void plan_place(ispl_pkg::in_word_t w);
    ispl_pkg::out_word_t        r;
    bit                         found;
    int unsigned                sel;
    logic [ispl_pkg::SizeW-1:0] best;
    logic [ispl_pkg::SizeW-1:0] growth;
    found = 1'b0;
    sel   = 0;
    best  = '0;
    for (int unsigned s = 0; s < slots_used; s++) begin
      if (slot_busy[s] < w.start_step) begin
        growth = (w.byte_count > slot_cap[s]) ? w.byte_count - slot_cap[s] : '0;
        if (!found || growth < best) begin
          found = 1'b1;
          sel   = s;
          best  = growth;
        end
      end
    end
    r = '0;
    r.echo_value_id = w.value_id;
    r.last          = 1'b1;
    if (found) begin
      if (w.byte_count > slot_cap[sel]) slot_cap[sel] = w.byte_count;
      slot_busy[sel]  = w.end_step;
      r.status        = ispl_pkg::StatusOk;
      r.slot_index    = ispl_pkg::SlotIdW'(sel);
      r.slot_valid    = 1'b1;
      r.slot_capacity = slot_cap[sel];
    end else if (slots_used >= SLOTS) begin
      r.status = ispl_pkg::StatusFull;
    end else begin
      slot_cap[slots_used]  = w.byte_count;
      slot_busy[slots_used] = w.end_step;
      r.status        = ispl_pkg::StatusOk;
      r.slot_index    = ispl_pkg::SlotIdW'(slots_used);
      r.opened_slot   = 1'b1;
      r.slot_valid    = 1'b1;
      r.slot_capacity = w.byte_count;
      slots_used++;
    end
    layout_q.insert(layout_q.size(), r);
  endfunction

  function automatic void plan_finish();
    ispl_pkg::out_word_t       r;
    int unsigned               lg;
    logic [63:0]               total;
    logic [63:0]               step;
    logic [ispl_pkg::OffW-1:0] offs [SLOTS];
    logic [1:0]                st;
    lg = (align_log2 > ispl_pkg::AlignMax) ? int'(ispl_pkg::AlignMax) : int'(align_log2);
    if (slots_used == 0) begin
      r      = '0;
      r.last = 1'b1;
      layout_q.insert(layout_q.size(), r);
      return;
    end
    total = '0;
    step  = 64'd1 << lg;
    for (int unsigned s = 0; s < slots_used; s++) begin
      total   = (total + step - 64'd1) & ~(step - 64'd1);
      offs[s] = total[ispl_pkg::OffW-1:0];
      total   = total + 64'(slot_cap[s]);
    end
    st = ((total >> ispl_pkg::OffW) != 0) ? ispl_pkg::StatusOverflow : ispl_pkg::StatusOk;
    for (int unsigned s = 0; s < slots_used; s++) begin
      r               = '0;
      r.status        = st;
      r.slot_index    = ispl_pkg::SlotIdW'(s);
      r.slot_valid    = 1'b1;
      r.slot_offset   = offs[s];
      r.slot_capacity = slot_cap[s];
      if (s + 1 == slots_used) begin
        r.total_bytes = total[ispl_pkg::OffW-1:0];
        r.last        = 1'b1;
      end
      layout_q.insert(layout_q.size(), r);
    end
    slots_used = 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layout_q.delete();
      slots_used   = 0;
      align_log2   = ispl_pkg::AlignReset;
      fail_total   = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == AlignAddr)
        align_log2 = pwdata_i[ispl_pkg::AlignW-1:0];
      if (out_valid_i && out_ready_i) begin
        if (layout_q.size() == 0) begin
          fail_total++;
          if (fail_total <= 10)
            $display("%0t: unexpected result word 0x%0h", $time, out_data_i);
        end else begin
          want = layout_q.pop_front();
          note_field("status",        want.status,        out_data_i.status);
          note_field("echo_value_id", want.echo_value_id, out_data_i.echo_value_id);
          note_field("slot_index",    want.slot_index,    out_data_i.slot_index);
          note_field("opened_slot",   want.opened_slot,   out_data_i.opened_slot);
          note_field("slot_valid",    want.slot_valid,    out_data_i.slot_valid);
          note_field("slot_offset",   want.slot_offset,   out_data_i.slot_offset);
          note_field("slot_capacity", want.slot_capacity, out_data_i.slot_capacity);
          note_field("total_bytes",   want.total_bytes,   out_data_i.total_bytes);
          note_field("last",          want.last,          out_data_i.last);
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.func == ispl_pkg::FuncFinish) plan_finish();
        else plan_place(in_data_i);
      end
      pending_o    <= layout_q.size();
      fail_count_o <= fail_total;
    end
  end

endmodule

// ----- test/tb_interval_slot_planner_core.sv -----
// ----------------------------------------------------------------------------
// tb_interval_slot_planner_core: testbench of the interval slot planner
// Drives directed and random place/finish words under several alignment
// settings, with random idling on both channels; the layout checker predicts
// and compares every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_interval_slot_planner_core;

  localparam int unsigned SlotMax    = 32;
  localparam int unsigned ItemTarget = 480;
  localparam int unsigned PhaseCnt   = 7;
  localparam logic [ispl_pkg::PaddrW-1:0] AlignAddr =
      ispl_pkg::PaddrW'(4 * int'(ispl_pkg::RegAlign));

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [ispl_pkg::PaddrW-1:0] paddr;
  logic [ispl_pkg::PdataW-1:0] pwdata;
  logic [ispl_pkg::PdataW-1:0] prdata;
  logic                        pready;

  int unsigned items_sent;
  int unsigned fails;
  int unsigned pending;
  int unsigned words_taken;
  bit          tx_burst;
  bit          rx_burst;
  bit          held_off;

  ispl_stream_if #(.T(ispl_pkg::in_word_t))  in_ch ();
  ispl_stream_if #(.T(ispl_pkg::out_word_t)) out_ch ();

  always #5 clk = ~clk;

  interval_slot_planner_core #(
    .MAX_SLOTS (SlotMax)
  ) dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_ch),
    .out_o   (out_ch)
  );

  ispl_layout_checker #(
    .SLOTS (SlotMax)
  ) u_layout_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_ch.valid),
    .in_ready_i   (in_ch.ready),
    .in_data_i    (in_ch.data),
    .out_valid_i  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .out_data_i   (out_ch.data),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap(bit burst);
    int unsigned r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ispl_pkg::SizeW-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r <= 3) return $urandom();
    if (r <= 5) return ispl_pkg::SizeW'($urandom_range(1, 8) * 64);
    return ispl_pkg::SizeW'($urandom_range(1, 4096));
  endfunction

  task automatic send_word(ispl_pkg::in_word_t w);
    int unsigned gap;
    gap = pick_gap(tx_burst);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.data  <= w;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic place(int unsigned first, int unsigned lastst,
                       logic [ispl_pkg::SizeW-1:0] sz, int unsigned vid);
    ispl_pkg::in_word_t w;
    w.func       = ispl_pkg::FuncPlace;
    w.start_step = ispl_pkg::StepW'(first);
    w.end_step   = ispl_pkg::StepW'(lastst);
    w.byte_count = sz;
    w.value_id   = ispl_pkg::IdW'(vid);
    send_word(w);
  endtask

  // payload of a finish word is don't-care, so fill it with noise
  task automatic finish_layout();
    ispl_pkg::in_word_t w;
    w.func       = ispl_pkg::FuncFinish;
    w.start_step = ispl_pkg::StepW'($urandom());
    w.end_step   = ispl_pkg::StepW'($urandom());
    w.byte_count = $urandom();
    w.value_id   = ispl_pkg::IdW'($urandom());
    send_word(w);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_write(logic [ispl_pkg::PaddrW-1:0] addr,
                           logic [ispl_pkg::PdataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // sorted lifetimes: first step non-decreasing, value id rising on equal steps
  task automatic run_sorted_burst();
    int unsigned n;
    int unsigned t;
    int unsigned vid;
    int unsigned adv;
    int unsigned life;
    int unsigned r;
    n   = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 12) : $urandom_range(13, 40);
    t   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 50);
    vid = $urandom_range(0, 65000);
    repeat (n) begin
      adv = $urandom_range(0, 3);
      if (adv != 0) begin
        t   = (t + adv > 65535) ? 65535 : t + adv;
        vid = $urandom_range(0, 65000);
      end else begin
        vid = (vid + 50 > 65535) ? 65535 : vid + $urandom_range(1, 50);
      end
      r = $urandom_range(0, 9);
      if (r < 7) life = $urandom_range(0, 12);
      else if (r < 9) life = $urandom_range(0, 200);
      else life = 65535;
      place(t, (t + life > 65535) ? 65535 : t + life, pick_size(), vid);
    end
    finish_layout();
  endtask

  // all lifetimes overlap, so the table fills and further places are refused
  task automatic run_pile_up();
    int unsigned t;
    int unsigned n;
    t = $urandom_range(0, 3);
    n = $urandom_range(SlotMax + 1, SlotMax + 6);
    for (int unsigned i = 0; i < n; i++)
      place(t, t + $urandom_range(0, 100), pick_size(), 100 + i);
    place(t + $urandom_range(50, 300), 65535, pick_size(), 100 + n);
    finish_layout();
  endtask

  task automatic run_noise();
    ispl_pkg::in_word_t w;
    repeat ($urandom_range(1, 8)) begin
      w.func       = ($urandom_range(0, 3) == 0) ? ispl_pkg::FuncFinish : ispl_pkg::FuncPlace;
      w.start_step = ispl_pkg::StepW'($urandom());
      w.end_step   = ispl_pkg::StepW'($urandom());
      w.byte_count = $urandom();
      w.value_id   = ispl_pkg::IdW'($urandom());
      send_word(w);
    end
  endtask

  // result side: random stalls, plus one long hold-off once traffic is going
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    words_taken = 0;
    held_off    = 1'b0;
    rx_burst    = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!held_off && words_taken >= 150) begin
        held_off = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      stall = pick_gap(rx_burst);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      words_taken++;
      if (words_taken % 64 == 0) rx_burst = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    int unsigned phase_align [PhaseCnt];
    int unsigned phase_end;
    int unsigned r;
    phase_align = '{0, 12, 15, 13, 3, 6, 0};
    phase_align[PhaseCnt-1] = $urandom_range(1, 11);
    items_sent = 0;
    tx_burst   = 1'b0;
    rst_n       <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, at the reset alignment
    finish_layout();                                  // empty table
    place(0, 5, 100, 1);                              // opens slot 0
    place(3, 10, 32'hFFFF_FFFF, 16'hFFFF);            // slot 0 still busy
    place(6, 65535, 50, 2);                           // reuses slot 0, no growth
    place(11, 12, 200, 3);                            // slot 1 free again
    place(13, 20, 0, 4);
    finish_layout();
    place(1, 2, 64, 10);
    place(1, 2, 64, 11);
    place(1, 4, 500, 12);
    place(5, 6, 400, 13);                             // least growth beats index
    place(5, 6, 10, 14);                              // tie, lowest index wins
    place(5, 6, 100, 15);
    finish_layout();
    place(65535, 65535, 32'hFFFF_FFFF, 16'hFFFF);
    place(65535, 0, 0, 0);                            // busy-until equal: not free
    place(65535, 65535, 32'hFFFF_FFFF, 16'h0001);
    finish_layout();
    place(40, 30, 7, 9);                              // out of order lifetime
    place(10, 65535, 1, 8);
    finish_layout();

    for (int unsigned p = 0; p < PhaseCnt; p++) begin
      drain();
      reg_write(AlignAddr, ispl_pkg::PdataW'(phase_align[p]));
      phase_end = ItemTarget * (p + 1) / PhaseCnt;
      if (p == 0) run_pile_up();
      while (items_sent < phase_end) begin
        tx_burst = ($urandom_range(0, 4) == 0);
        r = $urandom_range(0, 99);
        if (r < 70) run_sorted_burst();
        else if (r < 78) run_pile_up();
        else run_noise();
        if ($urandom_range(0, 19) == 0) drain();
      end
    end

    drain();
    repeat (100) @(posedge clk);
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/ispl_pkg.sv
hdl/ispl_stream_if.sv
hdl/ispl_ram.sv
hdl/interval_slot_planner_core.sv
test/ispl_layout_checker.sv
test/tb_interval_slot_planner_core.sv
